// ===== hw/rtl/glide_altitude_tracker_assert.svh =====
// Assertion macros of the checker of the glide altitude tracker.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef GLIDE_ALTITUDE_TRACKER_ASSERT_SVH
`define GLIDE_ALTITUDE_TRACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GAT_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GAT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/gat_pkg.sv =====
// Types, constants and helper functions of the glide altitude tracker.
// Depends on nothing; used by the interfaces, the datapath and the checker.
package gat_pkg;

  localparam int unsigned COORD_W    = 32;
  localparam int unsigned RATIO_W    = 16;
  localparam int unsigned ANGLE_W    = 2;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned FACTOR_W   = 17;
  localparam int unsigned PROD_W     = 2 * COORD_W;
  localparam int unsigned SUM_W      = PROD_W + 1;
  localparam int unsigned DIST_W     = 32;
  localparam int unsigned DROP_W     = 34;
  localparam int unsigned REM_W      = DIST_W + 2;
  localparam int unsigned NUM_SHIFT  = 24;
  localparam int unsigned SQRT_STEPS = DIST_W;
  localparam int unsigned QUO_BITS   = DROP_W;
  localparam int unsigned CNT_W      = $clog2(QUO_BITS);

  // Quotients at or above 2^34 are caught before the division starts.
  localparam int unsigned SAT_SHIFT = QUO_BITS - NUM_SHIFT;

  localparam logic [DROP_W-1:0]  DROP_MAX = DROP_W'(1) << (DROP_W - 1);
  localparam logic [RATIO_W-1:0] GLIDE_RATIO_RST = RATIO_W'(2560);

  // Cosine factors in unsigned Q1.16; a straight leg uses 1.0.
  localparam logic [FACTOR_W-1:0] COS_20  = FACTOR_W'(61584);
  localparam logic [FACTOR_W-1:0] COS_30  = FACTOR_W'(56756);
  localparam logic [FACTOR_W-1:0] COS_45  = FACTOR_W'(46341);
  localparam logic [FACTOR_W-1:0] COS_ONE = FACTOR_W'(65536);

  typedef enum logic [REQ_W-1:0] {
    REQ_START    = 2'd0,
    REQ_STRAIGHT = 2'd1,
    REQ_BANKED   = 2'd2
  } req_type_e;

  typedef enum logic [ANGLE_W-1:0] {
    ANGLE_20 = 2'd0,
    ANGLE_30 = 2'd1,
    ANGLE_45 = 2'd2
  } bank_angle_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLIDE_RATIO = 1'b0,
    CFG_BANK_ANGLE  = 1'b1
  } cfg_idx_e;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_DIFF = 9'b000000010,
    ST_SQX  = 9'b000000100,
    ST_SQY  = 9'b000001000,
    ST_EFF  = 9'b000010000,
    ST_ROOT = 9'b000100000,
    ST_CHK  = 9'b001000000,
    ST_DIV  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_e;

  // The unused angle code behaves as 45 degrees.
  function automatic logic [FACTOR_W-1:0] bank_factor(input logic [ANGLE_W-1:0] code);
    logic [FACTOR_W-1:0] f;
    case (bank_angle_e'(code))
      ANGLE_20: f = COS_20;
      ANGLE_30: f = COS_30;
      ANGLE_45: f = COS_45;
      default:  f = COS_45;
    endcase
    return f;
  endfunction

endpackage

// ===== hw/rtl/gat_in_if.sv =====
// Request channel of the glide altitude tracker: valid, ready and one point.
// Depends on gat_pkg.
interface gat_in_if import gat_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic signed [COORD_W-1:0] start_height;

  modport source (output valid, req_type, x_coord, y_coord, start_height, input ready);
  modport sink   (input valid, req_type, x_coord, y_coord, start_height, output ready);
endinterface

// ===== hw/rtl/gat_out_if.sv =====
// Result channel of the glide altitude tracker: valid, ready and the altitude.
// Depends on gat_pkg.
interface gat_out_if import gat_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] altitude;

  modport source (output valid, altitude, input ready);
  modport sink   (input valid, altitude, output ready);
endinterface

// ===== hw/rtl/gat_mul.sv =====
// Shared registered 32x32 unsigned multiplier of the glide altitude tracker.
// Depends on gat_pkg.
module gat_mul import gat_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [COORD_W-1:0] a_i,
  input  logic [COORD_W-1:0] b_i,
  output logic [PROD_W-1:0]  p_o
);

  logic [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= a_i * b_i;
    end
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/glide_altitude_tracker.sv =====
// Glide altitude tracker, top level. Depends on gat_pkg, gat_in_if, gat_out_if
// and gat_mul.
//
// The block follows an aircraft down a glide path one point at a time. A start
// request loads the position and altitude and returns that altitude. A straight
// or banked point request takes the horizontal distance from the previous point,
// floor(sqrt(dx^2 + dy^2)) saturated to 32 bits, and lowers the altitude by
// floor(distance * 2^24 / (glide_ratio * cos)), where cos is 1.0 on straight legs
// and the configured bank angle's cosine in Q1.16 on turns. The drop saturates at
// 2^33 and the altitude at the signed 32-bit minimum. Request type 3 changes
// nothing and returns the current altitude. Every request gives exactly one
// result. Coordinates and altitude share one fixed-point scale, so the fraction
// width does not enter the arithmetic. A start or unused request goes from the
// accepting state ST_IDLE straight to ST_FIN. A point request runs through
// ST_IDLE, ST_DIFF (differencing), ST_SQX, ST_SQY and ST_EFF on the shared
// multiplier (two squares and the effective ratio), ST_ROOT (the square root,
// one bit per cycle), ST_CHK (a check), ST_DIV (the restoring divider) and
// ST_FIN. When the drop is known to be zero or to saturate, the divider is
// skipped. Ready is high only while the sequencer is idle; the result sits in
// an output register, so the next request may be accepted while the previous
// result still waits. The final state ST_FIN repeats while an earlier result
// is still waiting. The two configuration registers are written through
// cfg_we_i / cfg_addr_i / cfg_wdata_i while the block is idle; the user must
// keep to this, as the block itself does not enforce it.
module glide_altitude_tracker import gat_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  gat_in_if.sink                in_i,
  gat_out_if.source             out_o
);

  // Local views of the channels.
  logic                      in_valid;
  logic                      in_ready;
  logic [REQ_W-1:0]          in_req_type;
  logic signed [COORD_W-1:0] in_x;
  logic signed [COORD_W-1:0] in_y;
  logic signed [COORD_W-1:0] in_start_height;
  logic                      out_valid;
  logic                      out_ready;
  logic signed [COORD_W-1:0] out_altitude;

  assign in_valid        = in_i.valid;
  assign in_req_type     = in_i.req_type;
  assign in_x            = in_i.x_coord;
  assign in_y            = in_i.y_coord;
  assign in_start_height = in_i.start_height;
  assign in_i.ready      = in_ready;
  assign out_ready       = out_o.ready;
  assign out_o.valid     = out_valid;
  assign out_o.altitude  = out_altitude;

  // Control state, configuration and the tracked point (all reset).
  state_e                    state_q, state_d;
  logic [RATIO_W-1:0]        glide_ratio_q, glide_ratio_d;
  logic [ANGLE_W-1:0]        bank_angle_q, bank_angle_d;
  logic signed [COORD_W-1:0] last_x_q, last_x_d;
  logic signed [COORD_W-1:0] last_y_q, last_y_d;
  logic signed [COORD_W-1:0] last_alt_q, last_alt_d;
  logic                      out_valid_q, out_valid_d;

  // Working registers of the sequencer (no reset needed).
  logic signed [COORD_W-1:0] pt_x_q, pt_x_d;
  logic signed [COORD_W-1:0] pt_y_q, pt_y_d;
  logic                      banked_q, banked_d;
  logic [COORD_W-1:0]        ax_q, ax_d;
  logic [COORD_W-1:0]        ay_q, ay_d;
  logic [SUM_W-1:0]          sum_q, sum_d;
  logic [REM_W-1:0]          rem_q, rem_d;
  logic [DIST_W-1:0]         root_q, root_d;
  logic [QUO_BITS-1:0]       nlo_q, nlo_d;
  logic [QUO_BITS-1:0]       quo_q, quo_d;
  logic [DROP_W-1:0]         drop_q, drop_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic signed [COORD_W-1:0] out_alt_q, out_alt_d;

  // Shared multiplier.
  logic               mul_en;
  logic [COORD_W-1:0] mul_a;
  logic [COORD_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;

  gat_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // The effective ratio (Q8.24) stays in the multiplier register from the
  // end of ST_EFF until the division is done.
  logic [COORD_W-1:0] eff_ratio;
  assign eff_ratio = prod[COORD_W-1:0];

  logic [FACTOR_W-1:0] factor;
  assign factor = banked_q ? bank_factor(bank_angle_q) : COS_ONE;

  // Coordinate differences; their magnitudes always fit in 32 bits.
  logic [COORD_W:0] dx;
  logic [COORD_W:0] dy;
  logic [COORD_W:0] dx_neg;
  logic [COORD_W:0] dy_neg;
  assign dx     = {pt_x_q[COORD_W-1], pt_x_q} - {last_x_q[COORD_W-1], last_x_q};
  assign dy     = {pt_y_q[COORD_W-1], pt_y_q} - {last_y_q[COORD_W-1], last_y_q};
  assign dx_neg = -dx;
  assign dy_neg = -dy;

  // One step of the square root: two radicand bits enter the remainder and
  // the trial value 4*root+1 is subtracted when it fits.
  logic [REM_W+1:0] sq_rem_sh;
  logic [REM_W+1:0] sq_trial;
  logic             sq_fit;
  logic [REM_W+1:0] sq_rem_sub;
  assign sq_rem_sh  = {rem_q, sum_q[PROD_W-1 -: 2]};
  assign sq_trial   = {2'b00, root_q, 2'b01};
  assign sq_fit     = (sq_rem_sh >= sq_trial);
  assign sq_rem_sub = sq_rem_sh - sq_trial;

  // Distance, saturated when the sum of squares went past 64 bits.
  logic [DIST_W-1:0] distance;
  assign distance = sum_q[SUM_W-1] ? {DIST_W{1'b1}} : root_q;

  // The quotient reaches 2^34 exactly when distance >= eff * 2^10.
  logic [DIST_W+SAT_SHIFT-1:0] sat_lhs;
  logic [DIST_W+SAT_SHIFT-1:0] sat_rhs;
  logic                        div_sat;
  assign sat_lhs = {{SAT_SHIFT{1'b0}}, distance};
  assign sat_rhs = {eff_ratio, {SAT_SHIFT{1'b0}}};
  assign div_sat = (sat_lhs >= sat_rhs);

  // One step of the restoring divider.
  logic [DIST_W+1:0] dv_rem_sh;
  logic [DIST_W+1:0] dv_div;
  logic              dv_fit;
  logic [DIST_W+1:0] dv_rem_sub;
  logic [QUO_BITS-1:0] dv_quo;
  assign dv_rem_sh  = {rem_q[DIST_W:0], nlo_q[QUO_BITS-1]};
  assign dv_div     = {2'b00, eff_ratio};
  assign dv_fit     = (dv_rem_sh >= dv_div);
  assign dv_rem_sub = dv_rem_sh - dv_div;
  assign dv_quo     = {quo_q[QUO_BITS-2:0], dv_fit};

  // New altitude, saturated at the signed minimum (it can only go down).
  logic [COORD_W+2:0]        alt_diff;
  logic signed [COORD_W-1:0] alt_sat;
  assign alt_diff = {{3{last_alt_q[COORD_W-1]}}, last_alt_q} - {1'b0, drop_q};
  assign alt_sat  = (alt_diff[COORD_W+2:COORD_W-1] == 4'b0000 ||
                     alt_diff[COORD_W+2:COORD_W-1] == 4'b1111)
                    ? alt_diff[COORD_W-1:0]
                    : {1'b1, {(COORD_W-1){1'b0}}};

  assign in_ready     = (state_q == ST_IDLE);
  assign out_valid    = out_valid_q;
  assign out_altitude = out_alt_q;

  always_comb begin
    state_d       = state_q;
    glide_ratio_d = glide_ratio_q;
    bank_angle_d  = bank_angle_q;
    last_x_d      = last_x_q;
    last_y_d      = last_y_q;
    last_alt_d    = last_alt_q;
    out_valid_d   = out_valid_q;
    pt_x_d        = pt_x_q;
    pt_y_d        = pt_y_q;
    banked_d      = banked_q;
    ax_d          = ax_q;
    ay_d          = ay_q;
    sum_d         = sum_q;
    rem_d         = rem_q;
    root_d        = root_q;
    nlo_d         = nlo_q;
    quo_d         = quo_q;
    drop_d        = drop_q;
    cnt_d         = cnt_q;
    out_alt_d     = out_alt_q;
    mul_en        = 1'b0;
    mul_a         = {{(COORD_W-RATIO_W){1'b0}}, glide_ratio_q};
    mul_b         = {{(COORD_W-FACTOR_W){1'b0}}, factor};

    // The user keeps configuration writes to idle; the block does not check.
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_GLIDE_RATIO: glide_ratio_d = cfg_wdata_i[RATIO_W-1:0];
        CFG_BANK_ANGLE:  bank_angle_d  = cfg_wdata_i[ANGLE_W-1:0];
        default: ;
      endcase
    end

    // The output register empties when the sink takes the result.
    if (out_valid_q && out_ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_valid) begin
          drop_d = '0;
          case (req_type_e'(in_req_type))
            REQ_START: begin
              last_x_d   = in_x;
              last_y_d   = in_y;
              last_alt_d = in_start_height;
              state_d    = ST_FIN;
            end
            REQ_STRAIGHT, REQ_BANKED: begin
              pt_x_d   = in_x;
              pt_y_d   = in_y;
              banked_d = (req_type_e'(in_req_type) == REQ_BANKED);
              state_d  = ST_DIFF;
            end
            default: begin
              // Unused request type: repeat the current altitude.
              state_d = ST_FIN;
            end
          endcase
        end
      end
      ST_DIFF: begin
        ax_d     = dx[COORD_W] ? dx_neg[COORD_W-1:0] : dx[COORD_W-1:0];
        ay_d     = dy[COORD_W] ? dy_neg[COORD_W-1:0] : dy[COORD_W-1:0];
        last_x_d = pt_x_q;
        last_y_d = pt_y_q;
        state_d  = ST_SQX;
      end
      ST_SQX: begin
        mul_en  = 1'b1;
        mul_a   = ax_q;
        mul_b   = ax_q;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        mul_en  = 1'b1;
        mul_a   = ay_q;
        mul_b   = ay_q;
        sum_d   = {1'b0, prod};
        state_d = ST_EFF;
      end
      ST_EFF: begin
        // The multiplier now forms glide_ratio * factor.
        mul_en  = 1'b1;
        sum_d   = sum_q + {1'b0, prod};
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = '0;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        rem_d  = sq_fit ? sq_rem_sub[REM_W-1:0] : sq_rem_sh[REM_W-1:0];
        root_d = {root_q[DIST_W-2:0], sq_fit};
        sum_d  = {sum_q[SUM_W-1], sum_q[PROD_W-3:0], 2'b00};
        cnt_d  = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (distance == '0) begin
          drop_d  = '0;
          state_d = ST_FIN;
        end else if (div_sat) begin
          // Also covers a zero glide ratio with a nonzero distance.
          drop_d  = DROP_MAX;
          state_d = ST_FIN;
        end else begin
          rem_d   = {{(REM_W-DIST_W+SAT_SHIFT){1'b0}}, distance[DIST_W-1:SAT_SHIFT]};
          nlo_d   = {distance[SAT_SHIFT-1:0], {NUM_SHIFT{1'b0}}};
          quo_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = {1'b0, dv_fit ? dv_rem_sub[DIST_W:0] : dv_rem_sh[DIST_W:0]};
        nlo_d = {nlo_q[QUO_BITS-2:0], 1'b0};
        quo_d = dv_quo;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(QUO_BITS - 1)) begin
          drop_d  = (dv_quo > DROP_MAX) ? DROP_MAX : dv_quo;
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        // Wait here until the output register is free.
        if (!out_valid_q || out_ready) begin
          last_alt_d  = alt_sat;
          out_alt_d   = alt_sat;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      glide_ratio_q <= GLIDE_RATIO_RST;
      bank_angle_q  <= ANGLE_30;
      last_x_q      <= '0;
      last_y_q      <= '0;
      last_alt_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      glide_ratio_q <= glide_ratio_d;
      bank_angle_q  <= bank_angle_d;
      last_x_q      <= last_x_d;
      last_y_q      <= last_y_d;
      last_alt_q    <= last_alt_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pt_x_q    <= pt_x_d;
    pt_y_q    <= pt_y_d;
    banked_q  <= banked_d;
    ax_q      <= ax_d;
    ay_q      <= ay_d;
    sum_q     <= sum_d;
    rem_q     <= rem_d;
    root_q    <= root_d;
    nlo_q     <= nlo_d;
    quo_q     <= quo_d;
    drop_q    <= drop_d;
    cnt_q     <= cnt_d;
    out_alt_q <= out_alt_d;
  end

endmodule

// ===== hw/rtl/gat_checker.sv =====
// Port-level checker of the glide altitude tracker and its bind statement.
// Depends on gat_pkg and glide_altitude_tracker_assert.svh.
`include "glide_altitude_tracker_assert.svh"

module gat_checker import gat_pkg::*; (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [REQ_W-1:0]          in_req_type,
  input logic signed [COORD_W-1:0] in_start_height,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [COORD_W-1:0] out_altitude
);

  logic in_fire;
  logic start_fire;
  assign in_fire    = in_valid && in_ready;
  assign start_fire = in_fire && (in_req_type == REQ_START) && !out_valid;

  // A result that is not taken stays put.
  `GAT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_altitude), "result changed while stalled")

  // The block is busy, with ready low, in the cycle after taking a request.
  `GAT_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_fire, !in_ready, "ready stayed high after a request")

  // A start request into an empty output returns its altitude through ST_FIN and the output register.
  `GAT_ASSERT_NEXT(a_start_echo, clk_i, rst_ni, start_fire, ##1 (out_valid && out_altitude == $past(in_start_height, 2)), "start altitude not returned")

endmodule

bind glide_altitude_tracker gat_checker u_gat_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_req_type     (in_req_type),
  .in_start_height (in_start_height),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_altitude    (out_altitude)
);

// ===== test/glide_altitude_tracker_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of the glide altitude tracker: random and directed glide paths,
// with an independent altitude predictor and in-order comparison of every result.
// Depends on gat_pkg, gat_in_if, gat_out_if and the glide_altitude_tracker RTL.
module glide_altitude_tracker_test;
  import gat_pkg::*;

  // Run length guard. About 1300 requests go through, so a correct run stays well below
  // this even under heavy stalls.
  localparam int unsigned LIMIT_CYCLES  = 1_000_000;
  localparam int unsigned PHASE_ITEMS   = 160;
  localparam int unsigned PHASE_COUNT   = 8;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned EFF_W         = RATIO_W + FACTOR_W;

  // Codes that the package enums leave out but the fields can still carry.
  localparam logic [REQ_W-1:0]   REQ_UNUSED  = 2'd3;
  localparam logic [ANGLE_W-1:0] ANGLE_SPARE = 2'd3;

  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
  localparam longint ALT_MIN = -64'sd2147483648;
  localparam longint ALT_MAX = 64'sd2147483647;

  typedef struct packed {
    logic [REQ_W-1:0]          kind;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] h;
  } point_req_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  gat_in_if  in_if ();
  gat_out_if out_if ();

  glide_altitude_tracker u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always #1 clk_i = ~clk_i;

  // Requests waiting to be offered, and altitudes predicted for accepted requests.
  point_req_t                pending_q[$];
  logic signed [COORD_W-1:0] altitude_q[$];
  logic signed [COORD_W-1:0] altitude_want;

  // The predictor's copy of the configuration and of the tracked position.
  logic [RATIO_W-1:0]        ratio_cfg;
  logic [ANGLE_W-1:0]        angle_cfg;
  logic signed [COORD_W-1:0] trk_x;
  logic signed [COORD_W-1:0] trk_y;
  logic signed [COORD_W-1:0] trk_alt;

  // Last position handed to the path generator, so that points can follow each other.
  logic [COORD_W-1:0] path_x;
  logic [COORD_W-1:0] path_y;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned error_count;
  int unsigned cycle_count;

  // Works out the altitude the block must return for one request and advances the
  // tracked state. Start loads the state, type 3 leaves it alone, and a point lowers
  // the altitude by floor(distance * 2^24 / (ratio * cos)) with saturation throughout.
  function automatic logic signed [COORD_W-1:0] track_point(input point_req_t p);
    logic [FACTOR_W-1:0]     factor;
    logic [EFF_W-1:0]        eff;
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic [DIST_W-1:0]       ax;
    logic [DIST_W-1:0]       ay;
    logic [DIST_W-1:0]       distance;
    logic [DIST_W-1:0]       trial;
    logic [64:0]             sq_sum;
    logic [63:0]             drop;
    longint                  lowered;
    int                      bit_pos;
    if (p.kind == REQ_START) begin
      trk_x   = p.x;
      trk_y   = p.y;
      trk_alt = p.h;
    end else if (p.kind == REQ_STRAIGHT || p.kind == REQ_BANKED) begin
      if (p.kind == REQ_STRAIGHT) begin
        factor = COS_ONE;
      end else begin
        // The spare angle code falls back to 45 degrees.
        case (angle_cfg)
          ANGLE_20: factor = COS_20;
          ANGLE_30: factor = COS_30;
          default:  factor = COS_45;
        endcase
      end
      dx = $signed({p.x[COORD_W-1], p.x}) - $signed({trk_x[COORD_W-1], trk_x});
      dy = $signed({p.y[COORD_W-1], p.y}) - $signed({trk_y[COORD_W-1], trk_y});
      ax = (dx < 0) ? DIST_W'(-dx) : DIST_W'(dx);
      ay = (dy < 0) ? DIST_W'(-dy) : DIST_W'(dy);
      sq_sum = 65'(ax) * 65'(ax) + 65'(ay) * 65'(ay);
      // Anything past 64 bits saturates the distance; otherwise build the floor of the
      // root one bit at a time from the top.
      if (sq_sum[64]) begin
        distance = '1;
      end else begin
        distance = '0;
        for (bit_pos = DIST_W - 1; bit_pos >= 0; bit_pos--) begin
          trial = distance | (DIST_W'(1) << bit_pos);
          if (64'(trial) * 64'(trial) <= sq_sum[63:0]) begin
            distance = trial;
          end
        end
      end
      eff = EFF_W'(ratio_cfg) * EFF_W'(factor);
      if (eff == '0) begin
        drop = (distance == '0) ? 64'd0 : 64'(DROP_MAX);
      end else begin
        drop = (64'(distance) << NUM_SHIFT) / 64'(eff);
      end
      if (drop > 64'(DROP_MAX)) begin
        drop = 64'(DROP_MAX);
      end
      lowered = longint'(trk_alt) - longint'(drop);
      if (lowered < ALT_MIN) begin
        trk_alt = COORD_MIN;
      end else if (lowered > ALT_MAX) begin
        trk_alt = COORD_MAX;
      end else begin
        trk_alt = lowered[COORD_W-1:0];
      end
      trk_x = p.x;
      trk_y = p.y;
    end
    return trk_alt;
  endfunction

  // A signed step for the next point: mostly moderate, sometimes zero, sometimes a far jump.
  function automatic logic [COORD_W-1:0] rand_step();
    logic [COORD_W-1:0] mag;
    case ($urandom_range(0, 7))
      0:       mag = '0;
      1:       mag = $urandom();
      default: mag = $urandom() >> $urandom_range(2, 30);
    endcase
    return ($urandom_range(0, 1) != 0) ? -mag : mag;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    error_count++;
  endtask

  task automatic push_req(input logic [REQ_W-1:0] kind, input logic [COORD_W-1:0] x,
                          input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] h);
    point_req_t p;
    p.kind = kind;
    p.x    = x;
    p.y    = y;
    p.h    = h;
    pending_q.push_back(p);
    if (kind != REQ_UNUSED) begin
      path_x = x;
      path_y = y;
    end
  endtask

  // Writes one register and mirrors it in the predictor. Only called while idle.
  task automatic write_register(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    if (idx == CFG_GLIDE_RATIO) begin
      ratio_cfg = data[RATIO_W-1:0];
    end else begin
      angle_cfg = data[ANGLE_W-1:0];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Holds the sender back until every accepted request has returned its result.
  task automatic settle_block();
    while (pending_q.size() != 0 || altitude_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
  endtask

  // Mostly well-formed glide paths: a start followed by a run of straight and banked
  // points with random steps. A small share is noise: type 3 requests and stray starts.
  task automatic queue_flight(input int unsigned n_items);
    int unsigned        run_left;
    logic [REQ_W-1:0]   kind;
    logic [COORD_W-1:0] height;
    run_left = 0;
    repeat (n_items) begin
      if ($urandom_range(0, 99) < 5) begin
        kind = ($urandom_range(0, 1) != 0) ? REQ_UNUSED : REQ_START;
        push_req(kind, $urandom(), $urandom(), $urandom());
      end else if (run_left == 0) begin
        case ($urandom_range(0, 7))
          0:       height = COORD_MAX;
          1:       height = COORD_MIN;
          2:       height = $urandom();
          default: height = $urandom() >> $urandom_range(1, 10);
        endcase
        push_req(REQ_START, path_x + rand_step(), path_y + rand_step(), height);
        run_left = $urandom_range(1, 24);
      end else begin
        kind = ($urandom_range(0, 1) != 0) ? REQ_BANKED : REQ_STRAIGHT;
        push_req(kind, path_x + rand_step(), path_y + rand_step(), $urandom());
        run_left--;
      end
    end
  endtask

  // Request driver. The predictor runs at the edge where a request is accepted, so it
  // sees exactly the configuration the block uses. Valid stays up until the request is
  // taken; between requests the sender may idle at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        altitude_q.push_back(track_point(pending_q.pop_front()));
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_if.valid        <= 1'b1;
          in_if.req_type     <= pending_q[0].kind;
          in_if.x_coord      <= pending_q[0].x;
          in_if.y_coord      <= pending_q[0].y;
          in_if.start_height <= pending_q[0].h;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every accepted result must match the oldest predicted altitude.
  // Ready is redrawn every cycle, which also stalls results that are already waiting.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (altitude_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, altitude %0d",
                                    out_if.altitude));
        end else begin
          altitude_want = altitude_q.pop_front();
          if (out_if.altitude !== altitude_want) begin
            report_mismatch($sformatf("altitude %0d, expected %0d",
                                      out_if.altitude, altitude_want));
          end
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned        phase_idx;
    logic [RATIO_W-1:0] new_ratio;
    logic [ANGLE_W-1:0] new_angle;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_addr_i         = CFG_GLIDE_RATIO;
    cfg_wdata_i        = '0;
    in_if.valid        = 1'b0;
    in_if.req_type     = REQ_START;
    in_if.x_coord      = '0;
    in_if.y_coord      = '0;
    in_if.start_height = '0;
    out_if.ready       = 1'b0;
    ratio_cfg          = GLIDE_RATIO_RST;
    angle_cfg          = ANGLE_30;
    trk_x              = '0;
    trk_y              = '0;
    trk_alt            = '0;
    path_x             = '0;
    path_y             = '0;
    error_count        = 0;
    cycle_count        = 0;
    // First stretch: the sender idles a little, the receiver a lot.
    send_idle_pct      = 18;
    recv_idle_pct      = 63;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part, under the reset configuration (ratio 10.0, 30 degrees).
    // Points before any start work from the origin at altitude zero.
    push_req(REQ_STRAIGHT, 32'h0180_0000, 32'h0200_0000, $urandom());
    push_req(REQ_BANKED, 32'h0, 32'h0, $urandom());
    push_req(REQ_UNUSED, $urandom(), $urandom(), $urandom());
    // Opposite corners: the squared distance overflows 64 bits and saturates.
    push_req(REQ_START, COORD_MIN, COORD_MIN, COORD_MAX);
    push_req(REQ_STRAIGHT, COORD_MAX, COORD_MAX, COORD_MIN);
    // Zero distance on both kinds of leg leaves the altitude as it is.
    push_req(REQ_STRAIGHT, COORD_MAX, COORD_MAX, 32'h0);
    push_req(REQ_BANKED, COORD_MAX, COORD_MAX, 32'h0);
    push_req(REQ_BANKED, COORD_MIN, COORD_MAX, 32'h0);
    // A unit step is far too short to lose any altitude.
    push_req(REQ_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    push_req(REQ_STRAIGHT, 32'h0, 32'h0, 32'hFFFF_FFFF);
    push_req(REQ_BANKED, 32'hFFFF_FFFF, 32'h0, 32'h0);
    // Starting at the floor: any drop pins the altitude at the signed minimum.
    push_req(REQ_START, 32'h0, 32'h0, COORD_MIN);
    push_req(REQ_STRAIGHT, 32'h0010_0000, 32'h0, 32'h0);
    push_req(REQ_START, 32'h0, 32'h0, COORD_MAX);
    push_req(REQ_BANKED, COORD_MAX, 32'h0, 32'h0);
    push_req(REQ_UNUSED, COORD_MIN, COORD_MAX, 32'h5555_5555);
    push_req(REQ_START, 32'h0303_9000, 32'hF95F_6C00, 32'h1F40_0000);
    push_req(REQ_STRAIGHT, 32'h0383_9000, 32'hF8DF_6C00, 32'hAAAA_AAAA);
    push_req(REQ_BANKED, 32'h0403_9000, 32'hF95F_6C00, 32'h0);
    settle_block();

    // Random phases. Each writes both registers while the block is idle; the sender
    // then waits for every result before the next phase, which also exercises a long
    // pause on the request side.
    for (phase_idx = 0; phase_idx < PHASE_COUNT; phase_idx++) begin
      if (phase_idx == 2) begin
        send_idle_pct = 63;
        recv_idle_pct = 18;
      end else if (phase_idx == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase_idx)
        0: begin
          new_ratio = 16'd1;
          new_angle = ANGLE_20;
        end
        1: begin
          new_ratio = 16'd65535;
          new_angle = ANGLE_45;
        end
        2: begin
          // A zero ratio drops any nonzero distance straight to the floor.
          new_ratio = 16'd0;
          new_angle = ANGLE_SPARE;
        end
        3: begin
          new_ratio = 16'd256;
          new_angle = ANGLE_30;
        end
        4: begin
          new_ratio = GLIDE_RATIO_RST;
          new_angle = ANGLE_SPARE;
        end
        default: begin
          new_ratio = RATIO_W'($urandom_range(1, 65535));
          new_angle = ANGLE_W'($urandom_range(0, 2));
        end
      endcase
      write_register(CFG_GLIDE_RATIO, new_ratio);
      write_register(CFG_BANK_ANGLE, CFG_DATA_W'(new_angle));
      push_req(REQ_START, path_x, path_y, $urandom());
      push_req(REQ_BANKED, path_x, path_y, 32'h0);
      push_req(REQ_STRAIGHT, path_x, path_y, 32'h0);
      queue_flight(PHASE_ITEMS);
      settle_block();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/gat_pkg.sv
hw/rtl/gat_in_if.sv
hw/rtl/gat_out_if.sv
hw/rtl/gat_mul.sv
hw/rtl/glide_altitude_tracker.sv
hw/rtl/gat_checker.sv
test/glide_altitude_tracker_test.sv
